### design/bls_pkg.sv
// bls_pkg: shared types, codes and defaults for the bounded lifo stack
// no dependencies; used by bls_ctrl, bls_datapath and bounded_lifo_stack
package bls_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int VALUE_WIDTH        = 32;
   localparam int CSR_WIDTH          = 7;

   localparam logic [CSR_WIDTH-1:0] CAPACITY_RESET = 7'd64;

   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_POP     = 2'd1;
   localparam logic [1:0] CMD_DISPLAY = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic push_we;   // write request value on top, count up
      logic pop_dec;   // count down
      logic rd_top;    // read top entry, walk pointer to top
      logic rd_next;   // step walk pointer down and read there
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic top_is_bottom;   // exactly one entry stored
      logic next_is_bottom;  // next walk step reaches entry zero
   } dp_status_type;

endpackage

### design/bls_datapath.sv
// bls_datapath: entry memory, entry count, walk pointer and capacity register
// depends on bls_pkg
module bls_datapath #(
   parameter int DEPTH      = bls_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bls_pkg::dp_cmd_type                    cmd,
   output bls_pkg::dp_status_type                 status,
   input  logic signed [bls_pkg::VALUE_WIDTH-1:0] push_value,
   input  logic                                   csr_write_enable,
   input  logic        [bls_pkg::CSR_WIDTH-1:0]   csr_write_data,
   output logic signed [bls_pkg::VALUE_WIDTH-1:0] rd_value
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_WIDTH-1:0]         mem [DEPTH];
   logic [DATA_WIDTH-1:0]         rd_data_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [ADDR_W-1:0]             ptr_ff;
   logic [bls_pkg::CSR_WIDTH-1:0] cap_ff;

   logic [CNT_W-1:0]              cap_sat;
   logic [CNT_W-1:0]              count_dec;
   logic [ADDR_W-1:0]             top_addr;
   logic [ADDR_W-1:0]             rd_addr;
   logic [DATA_WIDTH-1:0]         wr_data;
   logic signed [DATA_WIDTH-1:0]  rd_signed;
   logic signed [63:0]            rd_ext;

   assign cap_sat   = (cap_ff > bls_pkg::CSR_WIDTH'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_ff);
   assign count_dec = count_ff - CNT_W'(1);
   assign top_addr  = count_dec[ADDR_W-1:0];
   assign rd_addr   = cmd.rd_next ? (ptr_ff - ADDR_W'(1)) : top_addr;

   assign status.full           = (count_ff >= cap_sat);
   assign status.empty          = (count_ff == '0);
   assign status.top_is_bottom  = (count_ff == CNT_W'(1));
   assign status.next_is_bottom = (ptr_ff == ADDR_W'(1));

   // keep low bits on store, sign-extend on read
   assign wr_data   = DATA_WIDTH'({32'b0, push_value});
   assign rd_signed = rd_data_ff;
   assign rd_ext    = 64'(rd_signed);
   assign rd_value  = rd_ext[bls_pkg::VALUE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.push_we) begin
         mem[count_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (cmd.rd_top || cmd.rd_next) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         cap_ff   <= bls_pkg::CAPACITY_RESET;
      end else begin
         if (cmd.push_we) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.pop_dec) begin
            count_ff <= count_dec;
         end
         if (cmd.rd_top) begin
            ptr_ff <= top_addr;
         end else if (cmd.rd_next) begin
            ptr_ff <= ptr_ff - ADDR_W'(1);
         end
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_we |-> !status.full)
      else $error("write issued on full stack");

   a_pop_counts_down: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_dec |=> count_ff == $past(count_dec))
      else $error("pop did not lower entry count");

endmodule

### design/bls_ctrl.sv
// bls_ctrl: request/response state machine issuing datapath commands
// depends on bls_pkg
module bls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_command,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last,
   output logic                   value_en,
   output bls_pkg::dp_cmd_type    cmd,
   input  bls_pkg::dp_status_type status
);

   typedef enum logic {
      S_IDLE,
      S_RESP
   } state_type;

   state_type           state_ff;
   bls_pkg::status_type status_ff;
   logic                last_ff;
   logic                value_en_ff;
   logic                display_ff;
   logic                accept;
   logic                rsp_fire;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign accept     = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;
   assign value_en   = value_en_ff;

   always_comb begin
      cmd = '0;
      if (accept) begin
         unique case (req_command)
            bls_pkg::CMD_PUSH: begin
               cmd.push_we = !status.full;
            end
            bls_pkg::CMD_POP: begin
               cmd.pop_dec = !status.empty;
               cmd.rd_top  = !status.empty;
            end
            bls_pkg::CMD_DISPLAY: begin
               cmd.rd_top = !status.empty;
            end
            default: begin
            end
         endcase
      end
      if (rsp_fire && display_ff && !last_ff) begin
         cmd.rd_next = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         status_ff   <= bls_pkg::STATUS_OK;
         last_ff     <= 1'b0;
         value_en_ff <= 1'b0;
         display_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_command)
                     bls_pkg::CMD_PUSH: begin
                        status_ff   <= status.full ? bls_pkg::STATUS_FULL
                                                   : bls_pkg::STATUS_OK;
                        last_ff     <= 1'b1;
                        value_en_ff <= 1'b0;
                        display_ff  <= 1'b0;
                        state_ff    <= S_RESP;
                     end
                     bls_pkg::CMD_POP: begin
                        status_ff   <= status.empty ? bls_pkg::STATUS_EMPTY
                                                    : bls_pkg::STATUS_OK;
                        last_ff     <= 1'b1;
                        value_en_ff <= !status.empty;
                        display_ff  <= 1'b0;
                        state_ff    <= S_RESP;
                     end
                     bls_pkg::CMD_DISPLAY: begin
                        status_ff   <= status.empty ? bls_pkg::STATUS_EMPTY
                                                    : bls_pkg::STATUS_OK;
                        last_ff     <= status.empty || status.top_is_bottom;
                        value_en_ff <= !status.empty;
                        display_ff  <= !status.empty;
                        state_ff    <= S_RESP;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_RESP: begin
               if (rsp_fire) begin
                  if (cmd.rd_next) begin
                     last_ff <= status.next_is_bottom;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last |=> req_ready)
      else $error("not idle after final response");

   a_display_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> rsp_valid && status_ff == bls_pkg::STATUS_OK)
      else $error("display walk stopped early");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

endmodule

### design/bounded_lifo_stack.sv
// bounded_lifo_stack: top level of the lifo stack with programmable capacity
// depends on bls_pkg, bls_ctrl and bls_datapath
//
//   channel   direction  handshake                      payload
//   req       in         req_valid / req_ready          req_command, req_push_value
//   rsp       out        rsp_valid / rsp_ready          rsp_status, rsp_value, rsp_last
//   csr       in         csr_write_enable (no wait)     csr_write_data (capacity)
//
// push and pop: the accept cycle, then the response, held until rsp_ready takes it
// display of n entries gives n responses, one entry per cycle while rsp_ready is high,
// through the single registered read port of the entry memory
// reset (synchronous) clears the entry count and sets capacity to 64; no clearing pass
// a stalled response holds the machine in place; no request is taken until it is done
module bounded_lifo_stack #(
   parameter int DEPTH      = bls_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bls_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic        [1:0]                      req_command,
   input  logic signed [bls_pkg::VALUE_WIDTH-1:0] req_push_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [1:0]                      rsp_status,
   output logic signed [bls_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic                                   rsp_last,
   // capacity register write
   input  logic                                   csr_write_enable,
   input  logic        [bls_pkg::CSR_WIDTH-1:0]   csr_write_data
);

   bls_pkg::dp_cmd_type                    dp_cmd;
   bls_pkg::dp_status_type                 dp_status;
   logic signed [bls_pkg::VALUE_WIDTH-1:0] dp_value;
   logic                                   value_en;

   // sequencing: one request at a time, display walks the stack top down
   bls_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last),
      .value_en    (value_en),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   // storage, count, walk pointer, capacity
   bls_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .push_value       (req_push_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rd_value         (dp_value)
   );

   // value is zero for push results and empty status
   assign rsp_value = value_en ? dp_value : '0;

endmodule

### tb/sv/tb_bounded_lifo_stack.sv
// tb_bounded_lifo_stack: self-checking testbench for the bounded lifo stack
// holds a scoreboard class that predicts every response from accepted requests
// depends on bls_pkg and bounded_lifo_stack
import bls_pkg::*;

typedef struct {
   status_type             status;
   logic [VALUE_WIDTH-1:0] value;
   logic                   last;
} stack_reply_type;

// scoreboard: its own copy of the stack and the capacity register, plus the
// responses still owed by the block, oldest first
class stack_scoreboard;
   logic [VALUE_WIDTH-1:0] entries [DEPTH_DEFAULT];
   int unsigned            fill;
   logic [CSR_WIDTH-1:0]   capacity;
   stack_reply_type        pending_replies [$];
   int                     failures;

   function new();
      fill     = 0;
      capacity = CAPACITY_RESET;
      failures = 0;
   endfunction

   function void set_capacity(logic [CSR_WIDTH-1:0] c);
      capacity = c;
   endfunction

   // capacity values above the array size act as the array size
   function int unsigned usable();
      return (capacity > DEPTH_DEFAULT) ? DEPTH_DEFAULT : capacity;
   endfunction

   function int unsigned pending();
      return pending_replies.size();
   endfunction

   function void add_reply(status_type s, logic [VALUE_WIDTH-1:0] v, logic l);
      stack_reply_type r;
      r.status = s;
      r.value  = v;
      r.last   = l;
      pending_replies.push_back(r);
   endfunction

   function void note_request(logic [1:0] cmd, logic [VALUE_WIDTH-1:0] val);
      int unsigned k;
      case (cmd)
         CMD_PUSH: begin
            if (fill >= usable()) begin
               add_reply(STATUS_FULL, '0, 1'b1);
            end else begin
               entries[fill] = val;
               fill++;
               add_reply(STATUS_OK, '0, 1'b1);
            end
         end
         CMD_POP: begin
            if (fill == 0) begin
               add_reply(STATUS_EMPTY, '0, 1'b1);
            end else begin
               fill--;
               add_reply(STATUS_OK, entries[fill], 1'b1);
            end
         end
         CMD_DISPLAY: begin
            if (fill == 0) begin
               add_reply(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (k = 0; k < fill; k++)
                  add_reply(STATUS_OK, entries[fill - 1 - k], (k + 1 == fill));
            end
         end
         default: ;
      endcase
   endfunction

   function void check_response(logic [1:0] st, logic [VALUE_WIDTH-1:0] val, logic lst);
      stack_reply_type want;
      if (pending_replies.size() == 0) begin
         failures++;
         $display("%0t: unexpected response: got status %0d value %h last %b",
                  $time, st, val, lst);
         return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status || val !== want.value || lst !== want.last) begin
         failures++;
         $display({"%0t: response mismatch: expected status %0d value %h last %b,",
                   " got status %0d value %h last %b"},
                  $time, want.status, want.value, want.last, st, val, lst);
      end
   endfunction
endclass

module tb_bounded_lifo_stack;

   // the command code the block drops without a response
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_command      = CMD_PUSH;
   logic [VALUE_WIDTH-1:0] req_push_value   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [1:0]             rsp_status;
   logic [VALUE_WIDTH-1:0] rsp_value;
   logic                   rsp_last;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_WIDTH-1:0]   csr_write_data   = '0;

   // idling odds out of a hundred, changed per phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   stack_scoreboard book;

   bounded_lifo_stack u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 4 time unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: decide the stall for the next edge at each falling edge
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // every accepted response goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_response(rsp_status, rsp_value, rsp_last);
   end

   // one request; entered and left at a falling edge, valid left high so that
   // a following request can go out back to back
   task automatic send_request(input logic [1:0] cmd, input logic [VALUE_WIDTH-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_command    = cmd;
      req_push_value = val;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      book.note_request(cmd, val);
      @(negedge clock);
   endtask

   // let the block drain, give a dropped command time to pass through,
   // then write the capacity register while nothing is in flight
   task automatic write_capacity_when_idle(input logic [CSR_WIDTH-1:0] cap);
      req_valid = 1'b0;
      while (book.pending() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = cap;
      book.set_capacity(cap);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // random traffic in alternating fill and drain runs, so the stack swings
   // between empty and its capacity; display and dropped commands mixed in
   task automatic fill_drain_phase(input int items, input int idle_pct, input int stall_pct);
      int                     done;
      int                     pick;
      int                     push_odds;
      bit                     filling;
      logic [1:0]             cmd;
      logic [VALUE_WIDTH-1:0] val;
      done           = 0;
      filling        = 1'b1;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (done < items) begin
         if (book.fill >= book.usable())
            filling = 1'b0;
         else if (book.fill == 0)
            filling = 1'b1;
         else if ($urandom_range(0, 39) == 0)
            filling = !filling;
         push_odds = filling ? 75 : 25;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            cmd = CMD_UNUSED;
         else if (pick < 12)
            cmd = CMD_DISPLAY;
         else if ($urandom_range(0, 99) < push_odds)
            cmd = CMD_PUSH;
         else
            cmd = CMD_POP;
         case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = '1;
            default: val = $urandom;
         endcase
         send_request(cmd, val);
         // dropped commands do not count toward the phase
         if (cmd != CMD_UNUSED)
            done++;
      end
   endtask

   initial begin
      book = new();
      // synchronous reset held, then released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty stack, dropped command, extreme values, full display
      send_request(CMD_POP, 32'h1234_5678);
      send_request(CMD_DISPLAY, '0);
      send_request(CMD_UNUSED, 32'hdead_beef);
      send_request(CMD_PUSH, 32'h7fff_ffff);
      send_request(CMD_PUSH, 32'h8000_0000);
      send_request(CMD_PUSH, 32'hffff_ffff);
      send_request(CMD_PUSH, 32'h0000_0000);
      send_request(CMD_PUSH, 32'haaaa_aaaa);
      send_request(CMD_PUSH, 32'h5555_5555);
      send_request(CMD_DISPLAY, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);

      // capacity dropped below the count: pushes full until pops catch up
      write_capacity_when_idle(7'd2);
      send_request(CMD_PUSH, 32'h0bad_cafe);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_PUSH, 32'h1111_1111);
      send_request(CMD_POP, '0);
      send_request(CMD_PUSH, 32'h2222_2222);
      send_request(CMD_DISPLAY, '0);

      // zero capacity: every push full, pops still drain
      write_capacity_when_idle(7'd0);
      send_request(CMD_PUSH, 32'h3333_3333);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_PUSH, 32'h4444_4444);

      // random phases, each with its own capacity and idling pattern
      write_capacity_when_idle(7'd127);   // saturates to the array size
      fill_drain_phase(120, 0, 0);
      write_capacity_when_idle(7'd65);
      fill_drain_phase(120, 81, 0);
      write_capacity_when_idle(7'd9);     // likely below the count left over
      fill_drain_phase(120, 0, 81);
      write_capacity_when_idle(CSR_WIDTH'($urandom_range(0, 64)));
      fill_drain_phase(120, 26, 26);

      // drain and let the tail settle before the verdict
      req_valid = 1'b0;
      while (book.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
design/bls_pkg.sv
design/bls_datapath.sv
design/bls_ctrl.sv
design/bounded_lifo_stack.sv
tb/sv/tb_bounded_lifo_stack.sv
